[design/tts_pkg.sv]
// Shared types and constants for the task table scheduler.
// Used by tts_slot_mem, tts_csr, tts_core and task_table_scheduler; no dependencies.
package tts_pkg;

   // Table geometry
   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Field widths
   localparam int ID_W       = 64;
   localparam int HANDLE_W   = 32;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int TSTATE_W   = 2;
   localparam int OUTST_W    = 5;
   localparam int CFG_W      = 5;

   // Stream and register port widths
   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USED_W = STATUS_W + ID_W + HANDLE_W + TSTATE_W + 1 + OUTST_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_SUBMIT   = 3'd0,
      KIND_CANCEL   = 3'd1,
      KIND_RELEASE  = 3'd2,
      KIND_DISPATCH = 3'd3,
      KIND_COMPLETE = 3'd4,
      KIND_QUERY    = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_ARG   = 2'd1,
      STATUS_LIMIT = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [TSTATE_W-1:0] {
      TASK_QUEUED    = 2'd0,
      TASK_RUNNING   = 2'd1,
      TASK_COMPLETED = 2'd2,
      TASK_CANCELED  = 2'd3
   } task_state_type;

   typedef enum logic [0:0] {
      CSR_RUN_CAPACITY = 1'b0,
      CSR_SLOT_LIMIT   = 1'b1
   } csr_index_type;

   // Configuration register values
   typedef struct packed {
      logic [CFG_W-1:0] run_capacity;
      logic [CFG_W-1:0] slot_limit;
   } cfg_type;

   // Slot memory access from the core
   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                data_we;
      logic                state_we;
      logic [IDX_W-1:0]    wr_addr;
      logic [ID_W-1:0]     wr_id;
      logic [HANDLE_W-1:0] wr_handle;
      logic [TSTATE_W-1:0] wr_state;
   } mem_req_type;

endpackage

[design/task_table_scheduler.sv]
// Top level of the task table scheduler: streams, register port, core and slot memory.
// Depends on tts_pkg, tts_csr, tts_slot_mem and tts_core.
//
//   channel | direction | handshake             | contents
//   --------+-----------+-----------------------+-------------------------------------------
//   req_    | in        | req_tvalid/req_tready | tuser: kind; tdata: task_id, task_handle
//   rsp_    | out       | rsp_tvalid/rsp_tready | tdata: status_code .. outstanding
//   csr_    | in/out    | psel/penable/pready   | run_capacity @0x0, slot_limit @0x4
//
// One transaction at a time: the scan reads the first L = min(slot_limit, 16) slots,
// one slot a cycle from the slot memory's single read port (no scan when L is 0), then
// the finish step decides and writes back.
// The result sits in an output register; a stalled rsp_ holds the finish step only.
// Reset clears the slot valid bits and count at once; no clearing pass is needed.
module task_table_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tts_pkg::REQ_DATA_W-1:0]      req_tdata,  // task_id[63:0], task_handle[95:64]
   input  logic [tts_pkg::REQ_USER_W-1:0]      req_tuser,  // kind[2:0]
   // Response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status_code[1:0], result_id[65:2], result_handle[97:66], task_state[99:98],
   // was_canceled[100], outstanding[105:101], zero[111:106]
   output logic [tts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tts_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tts_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tts_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import tts_pkg::*;

   cfg_type              cfg;
   mem_req_type          mem_req;
   logic [ID_W-1:0]      rd_id;
   logic [HANDLE_W-1:0]  rd_handle;
   logic [TSTATE_W-1:0]  rd_state;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ID_W-1:0]      rsp_id;
   logic [HANDLE_W-1:0]  rsp_handle;
   logic [TSTATE_W-1:0]  rsp_state;
   logic                 rsp_canceled;
   logic [OUTST_W-1:0]   rsp_outstanding;

   tts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tts_slot_mem u_slot_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_id     (rd_id),
      .rd_handle (rd_handle),
      .rd_state  (rd_state)
   );

   tts_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_kind        (req_tuser[KIND_W-1:0]),
      .req_id          (req_tdata[ID_W-1:0]),
      .req_handle      (req_tdata[ID_W+HANDLE_W-1:ID_W]),
      .mem_req         (mem_req),
      .rd_id           (rd_id),
      .rd_handle       (rd_handle),
      .rd_state        (rd_state),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_id          (rsp_id),
      .rsp_handle      (rsp_handle),
      .rsp_state       (rsp_state),
      .rsp_canceled    (rsp_canceled),
      .rsp_outstanding (rsp_outstanding)
   );

   // Pack the response fields, lowest field first
   assign rsp_tdata = {(RSP_DATA_W - RSP_USED_W)'(0), rsp_outstanding, rsp_canceled,
                       rsp_state, rsp_handle, rsp_id, rsp_status};

`ifndef SYNTHESIS
   // One transaction at a time: no acceptance in the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a transaction is in progress");

   // The occupied count never exceeds the table size
   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_outstanding) <= SLOTS))
      else $error("outstanding count beyond table size");

   // Dispatch data only accompanies a successful result
   a_dispatch_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_status != STATUS_OK)) |-> ((rsp_id == '0) && (rsp_handle == '0)))
      else $error("result id or handle set on a failed transaction");

   // A cancel flag implies success
   a_cancel_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_canceled) |-> (rsp_status == STATUS_OK))
      else $error("was_canceled set on a failed transaction");
`endif

endmodule

[design/tts_slot_mem.sv]
// Slot storage: id/handle memory and task state memory, registered reads.
// Depends on tts_pkg.
module tts_slot_mem (
   input  logic                          clock,
   input  tts_pkg::mem_req_type          mem_req,
   output logic [tts_pkg::ID_W-1:0]      rd_id,
   output logic [tts_pkg::HANDLE_W-1:0]  rd_handle,
   output logic [tts_pkg::TSTATE_W-1:0]  rd_state
);
   import tts_pkg::*;

   logic [HANDLE_W+ID_W-1:0] data_mem [SLOTS];
   logic [TSTATE_W-1:0]      state_mem [SLOTS];
   logic [HANDLE_W+ID_W-1:0] data_rd_ff;
   logic [TSTATE_W-1:0]      state_rd_ff;

   // Write and read the id/handle memory
   always_ff @(posedge clock) begin
      if (mem_req.data_we) begin
         data_mem[mem_req.wr_addr] <= {mem_req.wr_handle, mem_req.wr_id};
      end
      if (mem_req.rd_en) begin
         data_rd_ff <= data_mem[mem_req.rd_addr];
      end
   end

   // Write and read the state memory
   always_ff @(posedge clock) begin
      if (mem_req.state_we) begin
         state_mem[mem_req.wr_addr] <= mem_req.wr_state;
      end
      if (mem_req.rd_en) begin
         state_rd_ff <= state_mem[mem_req.rd_addr];
      end
   end

   assign rd_id     = data_rd_ff[ID_W-1:0];
   assign rd_handle = data_rd_ff[HANDLE_W+ID_W-1:ID_W];
   assign rd_state  = state_rd_ff;

endmodule

[design/tts_csr.sv]
// Configuration registers run_capacity and slot_limit behind an APB-style port.
// Depends on tts_pkg.
module tts_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tts_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tts_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output tts_pkg::cfg_type                 cfg
);
   import tts_pkg::*;

   logic [CFG_W-1:0] run_capacity_ff;
   logic [CFG_W-1:0] slot_limit_ff;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Update the addressed register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         run_capacity_ff <= CFG_W'(1);
         slot_limit_ff   <= CFG_W'(16);
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            CSR_RUN_CAPACITY: run_capacity_ff <= csr_pwdata[CFG_W-1:0];
            CSR_SLOT_LIMIT:   slot_limit_ff   <= csr_pwdata[CFG_W-1:0];
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (csr_paddr[2])
         CSR_RUN_CAPACITY: csr_prdata = CSR_DATA_W'(run_capacity_ff);
         CSR_SLOT_LIMIT:   csr_prdata = CSR_DATA_W'(slot_limit_ff);
      endcase
   end

   assign cfg.run_capacity = run_capacity_ff;
   assign cfg.slot_limit   = slot_limit_ff;

endmodule

[design/tts_core.sv]
// Scheduler sequencer: scans the slot memory, decides the operation, writes back, holds result.
// Depends on tts_pkg; drives tts_slot_mem through a mem_req_type struct.
module tts_core (
   input  logic                          clock,
   input  logic                          reset,
   input  tts_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tts_pkg::KIND_W-1:0]    req_kind,
   input  logic [tts_pkg::ID_W-1:0]      req_id,
   input  logic [tts_pkg::HANDLE_W-1:0]  req_handle,
   output tts_pkg::mem_req_type          mem_req,
   input  logic [tts_pkg::ID_W-1:0]      rd_id,
   input  logic [tts_pkg::HANDLE_W-1:0]  rd_handle,
   input  logic [tts_pkg::TSTATE_W-1:0]  rd_state,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tts_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tts_pkg::ID_W-1:0]      rsp_id,
   output logic [tts_pkg::HANDLE_W-1:0]  rsp_handle,
   output logic [tts_pkg::TSTATE_W-1:0]  rsp_state,
   output logic                          rsp_canceled,
   output logic [tts_pkg::OUTST_W-1:0]   rsp_outstanding
);
   import tts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } seq_state_type;

   seq_state_type        state_ff, state_in;

   // Transaction being worked on
   logic [KIND_W-1:0]    op_kind_ff;
   logic [ID_W-1:0]      op_id_ff;
   logic [HANDLE_W-1:0]  op_handle_ff;
   logic [CNT_W-1:0]     vis_ff;

   // Scan pipeline
   logic [CNT_W-1:0]     issue_idx_ff;
   logic                 issue_done_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;

   // Scan results
   logic                 found_ff;
   logic [IDX_W-1:0]     match_idx_ff;
   logic [TSTATE_W-1:0]  match_state_ff;
   logic                 free_vld_ff;
   logic [IDX_W-1:0]     free_idx_ff;
   logic [CNT_W-1:0]     run_cnt_ff;
   logic                 best_vld_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [ID_W-1:0]      best_id_ff;
   logic [HANDLE_W-1:0]  best_handle_ff;

   // Table bookkeeping
   logic [SLOTS-1:0]     used_ff;
   logic [CNT_W-1:0]     occ_ff, occ_in;

   // Result register
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [HANDLE_W-1:0]  rsp_handle_ff;
   logic [TSTATE_W-1:0]  rsp_state_ff;
   logic                 rsp_canceled_ff;
   logic [OUTST_W-1:0]   rsp_outst_ff;

   logic [CNT_W-1:0]     vis;
   logic                 accept;
   logic                 issue;
   logic                 last_rd;
   logic                 rd_used;
   logic                 commit;

   // Decision of the finish step
   status_type           dec_status;
   logic [ID_W-1:0]      dec_id;
   logic [HANDLE_W-1:0]  dec_handle;
   logic [TSTATE_W-1:0]  dec_state;
   logic                 dec_canceled;
   logic                 dec_data_we;
   logic                 dec_state_we;
   logic [IDX_W-1:0]     dec_addr;
   logic [TSTATE_W-1:0]  dec_wr_state;
   logic                 dec_set_used;
   logic                 dec_clr_used;

   assign vis = (32'(cfg.slot_limit) < SLOTS) ? CNT_W'(cfg.slot_limit) : CNT_W'(SLOTS);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign issue     = (state_ff == ST_SCAN) & ~issue_done_ff;
   assign last_rd   = rd_vld_ff & ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == vis_ff);
   assign rd_used   = used_ff[rd_idx_ff];
   assign commit    = (state_ff == ST_FINISH) & (~rsp_valid_ff | rsp_ready);

   // Sequence: idle, scan slots below the limit, finish
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (vis == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_rd) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         if (accept) begin
            issue_done_ff <= 1'b0;
         end else if (issue && ((issue_idx_ff + CNT_W'(1)) == vis_ff)) begin
            issue_done_ff <= 1'b1;
         end
      end
   end

   // Capture the transaction and advance the read address
   always_ff @(posedge clock) begin
      if (accept) begin
         op_kind_ff   <= req_kind;
         op_id_ff     <= req_id;
         op_handle_ff <= req_handle;
         vis_ff       <= vis;
         issue_idx_ff <= '0;
      end else if (issue) begin
         issue_idx_ff <= issue_idx_ff + CNT_W'(1);
      end
      if (issue) begin
         rd_idx_ff <= issue_idx_ff[IDX_W-1:0];
      end
   end

   // Fold each slot read into the scan results
   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff    <= 1'b0;
         free_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
         run_cnt_ff  <= '0;
      end else if (rd_vld_ff) begin
         if (rd_used && (rd_id == op_id_ff) && !found_ff) begin
            found_ff       <= 1'b1;
            match_idx_ff   <= rd_idx_ff;
            match_state_ff <= rd_state;
         end
         if (!rd_used && !free_vld_ff) begin
            free_vld_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
         if (rd_used && (rd_state == TASK_RUNNING)) begin
            run_cnt_ff <= run_cnt_ff + CNT_W'(1);
         end
         if (rd_used && (rd_state == TASK_QUEUED) && (!best_vld_ff || (rd_id < best_id_ff))) begin
            best_vld_ff    <= 1'b1;
            best_idx_ff    <= rd_idx_ff;
            best_id_ff     <= rd_id;
            best_handle_ff <= rd_handle;
         end
      end
   end

   // Decide the outcome from the scan results
   always_comb begin
      dec_status   = STATUS_ARG;
      dec_id       = '0;
      dec_handle   = '0;
      dec_state    = TASK_QUEUED;
      dec_canceled = 1'b0;
      dec_data_we  = 1'b0;
      dec_state_we = 1'b0;
      dec_addr     = match_idx_ff;
      dec_wr_state = TASK_QUEUED;
      dec_set_used = 1'b0;
      dec_clr_used = 1'b0;
      unique case (op_kind_ff)
         KIND_SUBMIT: begin
            dec_status = STATUS_LIMIT;
            if ((occ_ff < vis_ff) && !found_ff && free_vld_ff) begin
               dec_status   = STATUS_OK;
               dec_data_we  = 1'b1;
               dec_state_we = 1'b1;
               dec_addr     = free_idx_ff;
               dec_wr_state = TASK_QUEUED;
               dec_set_used = 1'b1;
            end
         end
         KIND_CANCEL: begin
            if (found_ff) begin
               dec_status = STATUS_OK;
               if (match_state_ff == TASK_QUEUED) begin
                  dec_state_we = 1'b1;
                  dec_wr_state = TASK_CANCELED;
                  dec_canceled = 1'b1;
               end
            end
         end
         KIND_RELEASE: begin
            if (found_ff && ((match_state_ff == TASK_COMPLETED) ||
                             (match_state_ff == TASK_CANCELED))) begin
               dec_status   = STATUS_OK;
               dec_clr_used = 1'b1;
            end
         end
         KIND_DISPATCH: begin
            dec_status = STATUS_EMPTY;
            if ((32'(run_cnt_ff) < 32'(cfg.run_capacity)) && best_vld_ff) begin
               dec_status   = STATUS_OK;
               dec_state_we = 1'b1;
               dec_addr     = best_idx_ff;
               dec_wr_state = TASK_RUNNING;
               dec_id       = best_id_ff;
               dec_handle   = best_handle_ff;
            end
         end
         KIND_COMPLETE: begin
            if (found_ff && (match_state_ff == TASK_RUNNING)) begin
               dec_status   = STATUS_OK;
               dec_state_we = 1'b1;
               dec_wr_state = TASK_COMPLETED;
            end
         end
         KIND_QUERY: begin
            if (found_ff) begin
               dec_status = STATUS_OK;
               dec_state  = match_state_ff;
            end
         end
         default: begin
            dec_status = STATUS_ARG;
         end
      endcase
   end

   // Drive the slot memory: scan reads, finish write-back
   always_comb begin
      mem_req.rd_en     = issue;
      mem_req.rd_addr   = issue_idx_ff[IDX_W-1:0];
      mem_req.data_we   = commit & dec_data_we;
      mem_req.state_we  = commit & dec_state_we;
      mem_req.wr_addr   = dec_addr;
      mem_req.wr_id     = op_id_ff;
      mem_req.wr_handle = op_handle_ff;
      mem_req.wr_state  = dec_wr_state;
   end

   // Occupied count after the operation
   always_comb begin
      occ_in = occ_ff;
      if (commit && dec_set_used) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (commit && dec_clr_used) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         occ_ff  <= '0;
      end else begin
         occ_ff <= occ_in;
         if (commit && dec_set_used) begin
            used_ff[dec_addr] <= 1'b1;
         end else if (commit && dec_clr_used) begin
            used_ff[dec_addr] <= 1'b0;
         end
      end
   end

   // Hold the result until the downstream side takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff   <= dec_status;
         rsp_id_ff       <= dec_id;
         rsp_handle_ff   <= dec_handle;
         rsp_state_ff    <= dec_state;
         rsp_canceled_ff <= dec_canceled;
         rsp_outst_ff    <= OUTST_W'(occ_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_id          = rsp_id_ff;
   assign rsp_handle      = rsp_handle_ff;
   assign rsp_state       = rsp_state_ff;
   assign rsp_canceled    = rsp_canceled_ff;
   assign rsp_outstanding = rsp_outst_ff;

endmodule

[tb/sv/task_table_checker.sv]
// Scoreboard for the task table scheduler: watches the request, response and register ports.
// Predicts every response from its own copy of the slot table; depends on tts_pkg only.
module task_table_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [tts_pkg::REQ_DATA_W-1:0] req_tdata,   // task_id[63:0], task_handle[95:64]
   input  logic [tts_pkg::REQ_USER_W-1:0] req_tuser,   // kind[2:0]
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status_code[1:0], result_id[65:2], result_handle[97:66], task_state[99:98],
   // was_canceled[100], outstanding[105:101], zero[111:106]
   input  logic [tts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [tts_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             pending,
   output int                             failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import tts_pkg::*;

   // Bit offsets of the response fields
   localparam int RSP_ID_LSB     = STATUS_W;
   localparam int RSP_HANDLE_LSB = RSP_ID_LSB + ID_W;
   localparam int RSP_STATE_LSB  = RSP_HANDLE_LSB + HANDLE_W;
   localparam int RSP_CANCEL_BIT = RSP_STATE_LSB + TSTATE_W;
   localparam int RSP_OUTST_LSB  = RSP_CANCEL_BIT + 1;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     task_id;
      logic [HANDLE_W-1:0] handle;
      task_state_type      state;
      logic                canceled;
      logic [OUTST_W-1:0]  outstanding;
   } sched_result_type;

   // Shadow of the registers and the slot table
   logic [CFG_W-1:0]    run_capacity;
   logic [CFG_W-1:0]    slot_limit;
   logic                slot_busy        [SLOTS];
   logic [ID_W-1:0]     slot_task_id     [SLOTS];
   logic [HANDLE_W-1:0] slot_task_handle [SLOTS];
   task_state_type      slot_task_state  [SLOTS];
   int                  occupied;

   sched_result_type    due_results [$];

   function automatic int visible_slots();
      return (slot_limit < SLOTS) ? int'(slot_limit) : SLOTS;
   endfunction

   // Lowest visible busy slot holding the id, -1 when absent
   function automatic int slot_of_id(input logic [ID_W-1:0] id);
      int limit_n;
      limit_n = visible_slots();
      for (int i = 0; i < limit_n; i++) begin
         if (slot_busy[i] && slot_task_id[i] == id) return i;
      end
      return -1;
   endfunction

   // Apply one operation to the shadow table and return the response it gives
   function automatic sched_result_type schedule_op(input logic [KIND_W-1:0]   kind,
                                                    input logic [ID_W-1:0]     id,
                                                    input logic [HANDLE_W-1:0] handle);
      sched_result_type res;
      int               limit_n;
      int               hit;
      int               pick;
      int               running;
      limit_n    = visible_slots();
      hit        = slot_of_id(id);
      pick       = -1;
      running    = 0;
      res        = '0;
      res.status = STATUS_ARG;
      case (kind)
         KIND_SUBMIT: begin
            res.status = STATUS_LIMIT;
            if (occupied < limit_n && hit < 0) begin
               for (int i = 0; i < limit_n; i++) begin
                  if (!slot_busy[i] && pick < 0) pick = i;
               end
               if (pick >= 0) begin
                  slot_busy[pick]        = 1'b1;
                  slot_task_id[pick]     = id;
                  slot_task_handle[pick] = handle;
                  slot_task_state[pick]  = TASK_QUEUED;
                  occupied++;
                  res.status = STATUS_OK;
               end
            end
         end
         KIND_CANCEL: begin
            if (hit >= 0) begin
               res.status = STATUS_OK;
               if (slot_task_state[hit] == TASK_QUEUED) begin
                  slot_task_state[hit] = TASK_CANCELED;
                  res.canceled = 1'b1;
               end
            end
         end
         KIND_RELEASE: begin
            if (hit >= 0 && (slot_task_state[hit] == TASK_COMPLETED ||
                             slot_task_state[hit] == TASK_CANCELED)) begin
               slot_busy[hit] = 1'b0;
               occupied--;
               res.status = STATUS_OK;
            end
         end
         KIND_DISPATCH: begin
            res.status = STATUS_EMPTY;
            for (int i = 0; i < limit_n; i++) begin
               if (slot_busy[i] && slot_task_state[i] == TASK_RUNNING) running++;
            end
            if (running < run_capacity) begin
               // smallest queued id wins, lowest slot on a tie
               for (int i = 0; i < limit_n; i++) begin
                  if (slot_busy[i] && slot_task_state[i] == TASK_QUEUED &&
                      (pick < 0 || slot_task_id[i] < slot_task_id[pick])) pick = i;
               end
               if (pick >= 0) begin
                  slot_task_state[pick] = TASK_RUNNING;
                  res.task_id = slot_task_id[pick];
                  res.handle  = slot_task_handle[pick];
                  res.status  = STATUS_OK;
               end
            end
         end
         KIND_COMPLETE: begin
            if (hit >= 0 && slot_task_state[hit] == TASK_RUNNING) begin
               slot_task_state[hit] = TASK_COMPLETED;
               res.status = STATUS_OK;
            end
         end
         KIND_QUERY: begin
            if (hit >= 0) begin
               res.state  = slot_task_state[hit];
               res.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      res.outstanding = OUTST_W'(occupied);
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                       input logic [ID_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // Track register writes, check reads and responses, queue predictions
   always @(posedge clock) begin : watch
      sched_result_type want;
      logic             to_capacity;
      if (reset) begin
         run_capacity = CFG_W'(1);
         slot_limit   = CFG_W'(SLOTS);
         occupied     = 0;
         failures     = 0;
         for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
         due_results.delete();
         pending <= 0;
      end else begin
         to_capacity = (csr_index_type'(csr_paddr[2]) == CSR_RUN_CAPACITY);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite && to_capacity) run_capacity = csr_pwdata[CFG_W-1:0];
            else if (csr_pwrite) slot_limit = csr_pwdata[CFG_W-1:0];
            else check_field("prdata", to_capacity ? ID_W'(run_capacity) : ID_W'(slot_limit),
                             ID_W'(csr_prdata));
         end

         // Compare a response transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               failures++;
            end else begin
               want = due_results.pop_front();
               check_field("status_code", ID_W'(want.status), ID_W'(rsp_tdata[0 +: STATUS_W]));
               check_field("result_id", want.task_id, rsp_tdata[RSP_ID_LSB +: ID_W]);
               check_field("result_handle", ID_W'(want.handle),
                           ID_W'(rsp_tdata[RSP_HANDLE_LSB +: HANDLE_W]));
               check_field("task_state", ID_W'(want.state),
                           ID_W'(rsp_tdata[RSP_STATE_LSB +: TSTATE_W]));
               check_field("was_canceled", ID_W'(want.canceled),
                           ID_W'(rsp_tdata[RSP_CANCEL_BIT]));
               check_field("outstanding", ID_W'(want.outstanding),
                           ID_W'(rsp_tdata[RSP_OUTST_LSB +: OUTST_W]));
               check_field("padding", '0, ID_W'(rsp_tdata[RSP_DATA_W-1:RSP_USED_W]));
            end
         end

         if (req_tvalid && req_tready) begin
            due_results.push_back(schedule_op(req_tuser, req_tdata[0 +: ID_W],
                                              req_tdata[ID_W +: HANDLE_W]));
         end
         pending <= due_results.size();
      end
   end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for task_table_scheduler: clock, reset, register setup and request stimulus.
// Depends on tts_pkg, task_table_scheduler and task_table_checker, which does all checking.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tts_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;
   localparam int POOL_SIZE = 18;
   localparam int PHASES    = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // task_id[63:0], task_handle[95:64]
   logic [REQ_USER_W-1:0] req_tuser;    // kind[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // status_code[1:0], result_id[65:2], result_handle[97:66], task_state[99:98],
   // was_canceled[100], outstanding[105:101], zero[111:106]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    pending;
   int                    failures;

   bit                    calm;
   logic [ID_W-1:0]       id_pool [POOL_SIZE];

   // Register settings per phase, extremes included; one phase runs without gaps
   logic [CFG_W-1:0] capacity_plan [PHASES] = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd3, 5'd5, 5'd4};
   logic [CFG_W-1:0] limit_plan    [PHASES] = '{5'd16, 5'd16, 5'd4, 5'd3, 5'd31, 5'd1, 5'd0, 5'd10};
   int               items_plan    [PHASES] = '{60, 70, 60, 30, 70, 40, 20, 100};
   int               calm_phase = 4;

   task_table_scheduler i_dut (.*);

   task_table_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                          input logic [HANDLE_W-1:0] handle);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {handle, id};
      do @(posedge clock); while (!req_tready);
   endtask

   // Mostly ids from a small pool so that operations find their tasks
   task automatic send_random();
      int                  pick;
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
      pick = $urandom_range(0, 99);
      if (pick < 26) kind = KIND_SUBMIT;
      else if (pick < 36) kind = KIND_CANCEL;
      else if (pick < 50) kind = KIND_RELEASE;
      else if (pick < 68) kind = KIND_DISPATCH;
      else if (pick < 84) kind = KIND_COMPLETE;
      else if (pick < 97) kind = KIND_QUERY;
      else kind = $urandom_range(0, 1) ? KIND_UNUSED_7 : KIND_UNUSED_6;
      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (kind != KIND_SUBMIT && $urandom_range(0, 99) < 8) id = {$urandom, $urandom};
      pick = $urandom_range(0, 19);
      if (pick == 0) handle = '0;
      else if (pick == 1) handle = '1;
      else handle = $urandom;
      send_op(kind, id, handle);
   endtask

   // One register transfer; psel stays high so transfers can follow back to back
   task automatic csr_access(input logic write, input csr_index_type index,
                             input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word            = $urandom;
      word[CFG_W-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(index) << 2;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Write both registers, read them back, release the bus
   task automatic configure(input logic [CFG_W-1:0] capacity, input logic [CFG_W-1:0] limit);
      csr_access(1'b1, CSR_RUN_CAPACITY, capacity);
      csr_access(1'b1, CSR_SLOT_LIMIT, limit);
      csr_access(1'b0, CSR_RUN_CAPACITY, '0);
      csr_access(1'b0, CSR_SLOT_LIMIT, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold off until every response is in, then let the block settle
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Result side: random stalls between bursts of ready
   initial begin : rsp_pacing
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin : stimulus
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      calm        = 1'b0;
      id_pool[0]  = '0;
      id_pool[1]  = '1;
      id_pool[2]  = ID_W'(1);
      id_pool[3]  = '1 - 1;
      for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Check reset values of the registers
      csr_access(1'b0, CSR_RUN_CAPACITY, '0);
      csr_access(1'b0, CSR_SLOT_LIMIT, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;

      // Directed walk through every operation at reset settings
      send_op(KIND_QUERY, id_pool[0], $urandom);           // unknown id
      send_op(KIND_SUBMIT, id_pool[0], '0);                // zero handle
      send_op(KIND_SUBMIT, id_pool[1], '1);
      send_op(KIND_SUBMIT, id_pool[0], $urandom);          // duplicate
      send_op(KIND_CANCEL, id_pool[2], $urandom);          // unknown id
      send_op(KIND_DISPATCH, {$urandom, $urandom}, $urandom);
      send_op(KIND_DISPATCH, {$urandom, $urandom}, $urandom); // at run capacity
      send_op(KIND_QUERY, id_pool[0], $urandom);
      send_op(KIND_CANCEL, id_pool[0], $urandom);          // running, not canceled
      send_op(KIND_RELEASE, id_pool[0], $urandom);         // still running
      send_op(KIND_COMPLETE, id_pool[1], $urandom);        // queued, not running
      send_op(KIND_COMPLETE, id_pool[0], $urandom);
      send_op(KIND_QUERY, id_pool[0], $urandom);
      send_op(KIND_RELEASE, id_pool[0], $urandom);
      send_op(KIND_CANCEL, id_pool[1], $urandom);
      send_op(KIND_QUERY, id_pool[1], $urandom);
      send_op(KIND_DISPATCH, {$urandom, $urandom}, $urandom); // nothing queued
      send_op(KIND_RELEASE, id_pool[1], $urandom);
      send_op(KIND_UNUSED_6, id_pool[0], $urandom);
      send_op(KIND_UNUSED_7, id_pool[1], $urandom);
      send_op(KIND_COMPLETE, id_pool[3], $urandom);        // unknown id

      // Random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         drain(4);
         configure(capacity_plan[p], limit_plan[p]);
         calm = (p == calm_phase);
         for (int n = 0; n < items_plan[p]; n++) send_random();
      end
      calm = 1'b0;

      drain(20);
      if (failures == 0 && pending == 0) begin
         $display("PASS task_table_scheduler");
      end else begin
         $display("FAIL task_table_scheduler");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin : watchdog
      #5_000_000;
      $display("FAIL task_table_scheduler");
      $finish;
   end

endmodule
